// ===== rtl/msr_pkg.sv =====
// msr_pkg: shared widths, opcodes and state types for the modular square root block
// no dependencies
package msr_pkg;

    localparam int W     = 32;
    localparam int CNT_W = 5;
    localparam int SH_W  = 6;
    localparam int N_W   = 17;
    localparam logic [N_W-1:0] NRES_LAST = N_W'(65537);

    typedef enum logic {
        OP_POW,
        OP_MUL
    } ex_op_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_STEP,
        EX_SQR_GO,
        EX_SQR_WAIT,
        EX_MUL_GO,
        EX_MUL_WAIT,
        EX_NEXT,
        EX_DONE
    } ex_state_t;

    typedef enum logic [4:0] {
        T_IDLE,
        T_CHECK,
        T_REDUCE,
        T_FACTOR,
        T_EULER,
        T_ROOT1,
        T_NRES,
        T_XPOW,
        T_BPOW,
        T_GPOW,
        T_LOOP,
        T_TSQ,
        T_CSQ,
        T_XMUL,
        T_GMUL,
        T_BMUL,
        T_VERIFY,
        T_OUT
    } top_state_t;

endpackage

// ===== rtl/msr_mulmod.sv =====
// msr_mulmod: bit-serial modular multiplier, one multiplier bit per cycle
// depends on msr_pkg
module msr_mulmod
    import msr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] p,
    output logic         done,
    output logic [W-1:0] res
);

    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     x_reg, y_reg, p_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [W:0]       dbl, dbl_red, sum, sum_red;

    // acc = 2*acc mod p, then + x mod p when the top bit of y is set
    always_comb begin
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, p_reg}) ? dbl - {1'b0, p_reg} : dbl;
        sum      = dbl_red + {1'b0, x_reg};
        sum_red  = (sum >= {1'b0, p_reg}) ? sum - {1'b0, p_reg} : sum;
        acc_next = y_reg[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
            p_reg   <= p;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

// ===== rtl/msr_expo.sv =====
// msr_expo: modular exponentiation (left-to-right square and multiply) or single product
// depends on msr_pkg and msr_mulmod
module msr_expo
    import msr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  ex_op_t       op,
    input  logic [W-1:0] base,
    input  logic [W-1:0] expo,
    input  logic [W-1:0] p,
    output logic         done,
    output logic [W-1:0] res
);

    ex_state_t        state_reg, state_next;
    logic [W-1:0]     acc_reg, base_reg, e_reg, p_reg;
    logic [CNT_W-1:0] cnt_reg;
    ex_op_t           op_reg;
    logic             mm_start, mm_done;
    logic [W-1:0]     mm_y, mm_res;

    msr_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .x       (acc_reg),
        .y       (mm_y),
        .p       (p_reg),
        .done    (mm_done),
        .res     (mm_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EX_IDLE: begin
                if (start) begin
                    state_next = (op == OP_MUL) ? EX_MUL_GO : EX_STEP;
                end
            end
            EX_STEP: begin
                // squaring one is skipped
                if (acc_reg != W'(1)) begin
                    state_next = EX_SQR_GO;
                end else begin
                    state_next = e_reg[W-1] ? EX_MUL_GO : EX_NEXT;
                end
            end
            EX_SQR_GO:   state_next = EX_SQR_WAIT;
            EX_SQR_WAIT: begin
                if (mm_done) begin
                    state_next = e_reg[W-1] ? EX_MUL_GO : EX_NEXT;
                end
            end
            EX_MUL_GO:   state_next = EX_MUL_WAIT;
            EX_MUL_WAIT: begin
                if (mm_done) begin
                    state_next = (op_reg == OP_MUL) ? EX_DONE : EX_NEXT;
                end
            end
            EX_NEXT: state_next = (cnt_reg == '0) ? EX_DONE : EX_STEP;
            EX_DONE: state_next = EX_IDLE;
            default: state_next = EX_IDLE;
        endcase
    end

    always_comb begin
        mm_start = (state_reg == EX_SQR_GO) || (state_reg == EX_MUL_GO);
        if (state_reg == EX_SQR_GO) begin
            mm_y = acc_reg;
        end else begin
            mm_y = (op_reg == OP_MUL) ? e_reg : base_reg;
        end
        done = (state_reg == EX_DONE);
        res  = acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EX_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == EX_IDLE && start) begin
            op_reg   <= op;
            base_reg <= base;
            e_reg    <= expo;
            p_reg    <= p;
            cnt_reg  <= CNT_W'(W - 1);
            acc_reg  <= (op == OP_MUL) ? base : W'(1);
        end else if ((state_reg == EX_SQR_WAIT || state_reg == EX_MUL_WAIT) && mm_done) begin
            acc_reg <= mm_res;
        end else if (state_reg == EX_NEXT) begin
            e_reg   <= {e_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/modular_square_root_top.sv =====
// modular square root by tonelli-shanks on one shared bit-serial modular multiplier
// throughput: one item at a time, s_ready is high only while idle
// reset: synchronous active-low aresetn returns the sequencer to idle, no output valid
module modular_square_root_top
    import msr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [W-1:0] s_residue,
    input  logic [W-1:0] s_prime_modulus,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [W-1:0] m_root_first,
    output logic [W-1:0] m_root_second,
    output logic         m_no_root
);

    top_state_t      state_reg, state_next;
    logic [W-1:0]    a_reg, a_next, p_reg, p_next, s_reg, s_next;
    logic [W-1:0]    x_reg, x_next, b_reg, b_next, g_reg, g_next;
    logic [W-1:0]    t_reg, t_next, c_reg, c_next;
    logic [N_W-1:0]  n_reg, n_next;
    logic [SH_W-1:0] j_reg, j_next, r_reg, r_next, i_reg, i_next, k_reg, k_next;
    logic            issued_reg, issued_next;
    logic [W-1:0]    r1_reg, r1_next, r2_reg, r2_next;
    logic            nr_reg, nr_next;

    logic            ex_start, ex_done;
    ex_op_t          ex_op;
    logic [W-1:0]    ex_base, ex_exp, ex_res;
    logic [W-1:0]    pm1, half;
    logic            bad_mod, nres_ok, tsq_go, tsq_fail, csq_go;

    msr_expo u_expo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ex_start),
        .op      (ex_op),
        .base    (ex_base),
        .expo    (ex_exp),
        .p       (p_reg),
        .done    (ex_done),
        .res     (ex_res)
    );

    assign pm1      = p_reg - 1'b1;
    assign half     = pm1 >> 1;
    assign bad_mod  = (p_reg < W'(3)) || !p_reg[0];
    assign nres_ok  = ({{(W-N_W){1'b0}}, n_reg} < p_reg) && (n_reg <= NRES_LAST);
    assign tsq_go   = (t_reg != W'(1)) && (i_reg < r_reg);
    assign tsq_fail = (t_reg != W'(1)) || (i_reg >= r_reg);
    assign csq_go   = (k_reg + 1'b1) < (r_reg - i_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:   if (s_valid) state_next = T_CHECK;
            T_CHECK:  state_next = bad_mod ? T_OUT : T_REDUCE;
            T_REDUCE: begin
                if (ex_done) state_next = (ex_res == '0) ? T_OUT : T_FACTOR;
            end
            T_FACTOR: if (s_reg[0]) state_next = T_EULER;
            T_EULER: begin
                if (ex_done) begin
                    if (ex_res != W'(1)) begin
                        state_next = T_OUT;
                    end else begin
                        state_next = (j_reg == SH_W'(1)) ? T_ROOT1 : T_NRES;
                    end
                end
            end
            T_ROOT1:  if (ex_done) state_next = T_VERIFY;
            T_NRES: begin
                if (!issued_reg && !nres_ok) begin
                    state_next = T_OUT;
                end else if (ex_done && ex_res == pm1) begin
                    state_next = T_XPOW;
                end
            end
            T_XPOW:   if (ex_done) state_next = T_BPOW;
            T_BPOW:   if (ex_done) state_next = T_GPOW;
            T_GPOW:   if (ex_done) state_next = T_LOOP;
            T_LOOP:   state_next = (b_reg == W'(1)) ? T_VERIFY : T_TSQ;
            T_TSQ: begin
                if (!issued_reg && !tsq_go) state_next = tsq_fail ? T_OUT : T_CSQ;
            end
            T_CSQ:    if (!issued_reg && !csq_go) state_next = T_XMUL;
            T_XMUL:   if (ex_done) state_next = T_GMUL;
            T_GMUL:   if (ex_done) state_next = T_BMUL;
            T_BMUL:   if (ex_done) state_next = T_LOOP;
            T_VERIFY: if (ex_done) state_next = T_OUT;
            T_OUT:    if (m_ready) state_next = T_IDLE;
            default:  state_next = T_IDLE;
        endcase
    end

    // outputs, unit commands and datapath
    always_comb begin
        a_next = a_reg;  p_next = p_reg;  s_next = s_reg;
        x_next = x_reg;  b_next = b_reg;  g_next = g_reg;
        t_next = t_reg;  c_next = c_reg;  n_next = n_reg;
        j_next = j_reg;  r_next = r_reg;  i_next = i_reg;  k_next = k_reg;
        r1_next = r1_reg;  r2_next = r2_reg;  nr_next = nr_reg;
        ex_op   = OP_POW;
        ex_base = a_reg;
        ex_exp  = s_reg;
        ex_start = 1'b0;
        s_ready = (state_reg == T_IDLE);
        m_valid = (state_reg == T_OUT);

        case (state_reg)
            T_IDLE: begin
                a_next = s_residue;
                p_next = s_prime_modulus;
            end
            T_CHECK: begin
                r1_next = '0;  r2_next = '0;  nr_next = 1'b1;
            end
            T_REDUCE: begin
                // a mod p as the product 1 * a
                ex_op = OP_MUL;  ex_base = W'(1);  ex_exp = a_reg;
                ex_start = !issued_reg;
                if (ex_done) begin
                    a_next  = ex_res;
                    s_next  = pm1;
                    j_next  = '0;
                    nr_next = 1'b0;
                end
            end
            T_FACTOR: begin
                if (!s_reg[0]) begin
                    s_next = s_reg >> 1;
                    j_next = j_reg + 1'b1;
                end
                n_next = N_W'(2);
                nr_next = 1'b1;
            end
            T_EULER: begin
                ex_exp = half;
                ex_start = !issued_reg;
            end
            T_ROOT1: begin
                ex_exp = (p_reg >> 2) + 1'b1;
                ex_start = !issued_reg;
                if (ex_done) x_next = ex_res;
            end
            T_NRES: begin
                ex_base = {{(W-N_W){1'b0}}, n_reg};
                ex_exp  = half;
                ex_start = !issued_reg && nres_ok;
                if (ex_done && ex_res != pm1) n_next = n_reg + 1'b1;
            end
            T_XPOW: begin
                ex_exp = (s_reg >> 1) + 1'b1;
                ex_start = !issued_reg;
                if (ex_done) x_next = ex_res;
            end
            T_BPOW: begin
                ex_start = !issued_reg;
                if (ex_done) b_next = ex_res;
            end
            T_GPOW: begin
                ex_base = {{(W-N_W){1'b0}}, n_reg};
                ex_start = !issued_reg;
                if (ex_done) begin
                    g_next = ex_res;
                    r_next = j_reg;
                end
            end
            T_LOOP: begin
                t_next = b_reg;
                i_next = '0;
            end
            T_TSQ: begin
                ex_op = OP_MUL;  ex_base = t_reg;  ex_exp = t_reg;
                ex_start = !issued_reg && tsq_go;
                if (ex_done) begin
                    t_next = ex_res;
                    i_next = i_reg + 1'b1;
                end
                if (!issued_reg && !tsq_go) begin
                    c_next = g_reg;
                    k_next = '0;
                end
            end
            T_CSQ: begin
                ex_op = OP_MUL;  ex_base = c_reg;  ex_exp = c_reg;
                ex_start = !issued_reg && csq_go;
                if (ex_done) begin
                    c_next = ex_res;
                    k_next = k_reg + 1'b1;
                end
            end
            T_XMUL: begin
                ex_op = OP_MUL;  ex_base = x_reg;  ex_exp = c_reg;
                ex_start = !issued_reg;
                if (ex_done) x_next = ex_res;
            end
            T_GMUL: begin
                ex_op = OP_MUL;  ex_base = c_reg;  ex_exp = c_reg;
                ex_start = !issued_reg;
                if (ex_done) g_next = ex_res;
            end
            T_BMUL: begin
                ex_op = OP_MUL;  ex_base = b_reg;  ex_exp = g_reg;
                ex_start = !issued_reg;
                if (ex_done) begin
                    b_next = ex_res;
                    r_next = i_reg;
                end
            end
            T_VERIFY: begin
                // square the root back and compare with the reduced value
                ex_op = OP_MUL;  ex_base = x_reg;  ex_exp = x_reg;
                ex_start = !issued_reg;
                if (ex_done && ex_res == a_reg) begin
                    r1_next = x_reg;
                    r2_next = (x_reg == '0) ? '0 : p_reg - x_reg;
                    nr_next = 1'b0;
                end
            end
            default: begin
            end
        endcase

        issued_next = issued_reg;
        if (ex_start) issued_next = 1'b1;
        if (ex_done)  issued_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;  p_reg <= p_next;  s_reg <= s_next;
        x_reg <= x_next;  b_reg <= b_next;  g_reg <= g_next;
        t_reg <= t_next;  c_reg <= c_next;  n_reg <= n_next;
        j_reg <= j_next;  r_reg <= r_next;  i_reg <= i_next;  k_reg <= k_next;
        r1_reg <= r1_next;  r2_reg <= r2_next;  nr_reg <= nr_next;
    end

    assign m_root_first  = r1_reg;
    assign m_root_second = r2_reg;
    assign m_no_root     = nr_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides open at once");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_root |-> m_root_first == '0 && m_root_second == '0)
        else $error("failed item carries nonzero roots");

    a_roots_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_no_root && m_root_first != '0
        |-> ({1'b0, m_root_first} + {1'b0, m_root_second}) == {1'b0, p_reg})
        else $error("roots do not sum to the modulus");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == T_CHECK && !issued_reg)
        else $error("accepted item did not start the sequence");
`endif

endmodule
